FILE: sv/bgbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbe_pkg: shared types and constants of the grid boundary edge extractor
// Holds the configuration register map, the job and result records and
// the table of the twelve result positions per finished cell.
// ----------------------------------------------------------------------------
package bgbe_pkg;

    localparam int SIZE_W      = 9;   // grid_width / grid_height register width
    localparam int CELL_W      = 5;   // cell_size register width
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int COORD_W     = 13;
    localparam int N_SLOTS     = 12;
    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_CELL_SIZE   = 2'd2
    } t_cfg_idx;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_POINT   = 1'b1;

    // result positions, in emission order
    localparam logic [SLOT_W-1:0] SLOT_TOP_SEG       = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_TOP_PT_TL     = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_TOP_PT_TR     = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT_SEG     = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT_PT_TR   = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT_PT_BR   = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_BOTTOM_SEG    = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_BOTTOM_PT_BR  = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_BOTTOM_PT_BL  = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_LEFT_SEG      = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_LEFT_PT_BL    = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_LEFT_PT_TL    = 4'd11;

    typedef struct packed {
        logic [N_SLOTS-1:0] mask;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } t_result;

    // Which positions fire, from the four empty-neighbor flags.
    function automatic logic [N_SLOTS-1:0] build_mask(input logic e_top, input logic e_right,
                                                      input logic e_bottom, input logic e_left);
        logic [N_SLOTS-1:0] m;
        m                    = '0;
        m[SLOT_TOP_SEG]      = e_top;
        m[SLOT_TOP_PT_TL]    = e_top & e_left;
        m[SLOT_TOP_PT_TR]    = e_top & e_right;
        m[SLOT_RIGHT_SEG]    = e_right;
        m[SLOT_RIGHT_PT_TR]  = e_right & e_top;
        m[SLOT_RIGHT_PT_BR]  = e_right & e_bottom;
        m[SLOT_BOTTOM_SEG]   = e_bottom;
        m[SLOT_BOTTOM_PT_BR] = e_bottom & e_right;
        m[SLOT_BOTTOM_PT_BL] = e_bottom & e_left;
        m[SLOT_LEFT_SEG]     = e_left;
        m[SLOT_LEFT_PT_BL]   = e_left & e_bottom;
        m[SLOT_LEFT_PT_TL]   = e_left & e_top;
        return m;
    endfunction

    function automatic t_result mk_seg(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                       input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        t_result r;
        r.kind = KIND_SEGMENT;
        r.sx   = sx;
        r.sy   = sy;
        r.ex   = ex;
        r.ey   = ey;
        return r;
    endfunction

    function automatic t_result mk_pt(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        t_result r;
        r.kind = KIND_POINT;
        r.sx   = px;
        r.sy   = py;
        r.ex   = px;
        r.ey   = py;
        return r;
    endfunction

    function automatic t_result slot_result(input logic [SLOT_W-1:0] slot, input t_job job);
        t_result r;
        unique case (slot)
            SLOT_TOP_SEG:      r = mk_seg(job.x0, job.y0, job.x1, job.y0);
            SLOT_TOP_PT_TL:    r = mk_pt(job.x0, job.y0);
            SLOT_TOP_PT_TR:    r = mk_pt(job.x1, job.y0);
            SLOT_RIGHT_SEG:    r = mk_seg(job.x1, job.y0, job.x1, job.y1);
            SLOT_RIGHT_PT_TR:  r = mk_pt(job.x1, job.y0);
            SLOT_RIGHT_PT_BR:  r = mk_pt(job.x1, job.y1);
            SLOT_BOTTOM_SEG:   r = mk_seg(job.x1, job.y1, job.x0, job.y1);
            SLOT_BOTTOM_PT_BR: r = mk_pt(job.x1, job.y1);
            SLOT_BOTTOM_PT_BL: r = mk_pt(job.x0, job.y1);
            SLOT_LEFT_SEG:     r = mk_seg(job.x0, job.y1, job.x0, job.y0);
            SLOT_LEFT_PT_BL:   r = mk_pt(job.x0, job.y1);
            SLOT_LEFT_PT_TL:   r = mk_pt(job.x0, job.y0);
            default:           r = mk_seg(job.x0, job.y0, job.x0, job.y0);
        endcase
        return r;
    endfunction

endpackage

FILE: sv/bgbe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbe_front: cell intake, column ring store and cell classification
// Tracks the raster position, keeps the last three columns in two mirrored
// one-bit stores (two read ports each) and turns every finished solid cell
// with an empty neighbor into a job for the result sequencer.
// ----------------------------------------------------------------------------
module bgbe_front #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cell_solid,
    input  logic [bgbe_pkg::SIZE_W-1:0] i_grid_width,
    input  logic [bgbe_pkg::SIZE_W-1:0] i_grid_height,
    input  logic [bgbe_pkg::CELL_W-1:0] i_cell_size,
    input  bgbe_pkg::t_fifo_stat        i_q_stat,
    output logic                        o_push,
    output bgbe_pkg::t_job              o_job
);
    import bgbe_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS + 2);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int LCW   = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int LHW   = (HW > SIZE_W) ? HW : SIZE_W;
    localparam int DEPTH = 3 * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PXW   = (CW + CELL_W > COORD_W) ? CW + CELL_W : COORD_W;
    localparam int PYW   = (RW + CELL_W > COORD_W) ? RW + CELL_W : COORD_W;

    localparam logic [LCW-1:0] MAXC = LCW'(MAX_COLUMNS);
    localparam logic [LHW-1:0] MAXR = LHW'(MAX_ROWS);

    function automatic logic [1:0] inc3(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [1:0] slot, input logic [RW-1:0] row);
        logic [AW-1:0] base;
        unique case (slot)
            2'd1:    base = AW'(MAX_ROWS);
            2'd2:    base = AW'(2 * MAX_ROWS);
            default: base = '0;
        endcase
        return base + AW'(row);
    endfunction

    // effective grid size, clamped to 1..MAX
    logic [LCW-1:0] w_ext, w_lim;
    logic [LHW-1:0] h_ext, h_lim;
    logic [CW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;

    assign w_ext = LCW'(i_grid_width);
    assign h_ext = LHW'(i_grid_height);
    assign w_lim = (w_ext == '0) ? LCW'(1) : ((w_ext > MAXC) ? MAXC : w_ext);
    assign h_lim = (h_ext == '0) ? LHW'(1) : ((h_ext > MAXR) ? MAXR : h_ext);
    assign w_eff = CW'(w_lim);
    assign h_eff = HW'(h_lim);

    // raster position; r_slot is r_col mod 3
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [1:0]    r_slot, n_slot;

    logic          roll, wrap, last_row;
    logic [CW-1:0] col_pre, col_c;
    logic [1:0]    slot_pre, slot_c, slot_x, slot_xm;
    logic [RW-1:0] row_c;
    logic [HW-1:0] row_plus;
    logic          has_above, has_below, has_left, has_right, finish, wr_en;
    logic [AW-1:0] addr_above, addr_below, addr_cell, addr_left, addr_wr;

    logic          accept, s1_go, emit;

    always_comb begin
        roll     = HW'(r_row) >= h_eff;
        col_pre  = roll ? r_col + CW'(1) : r_col;
        slot_pre = roll ? inc3(r_slot) : r_slot;
        wrap     = col_pre > w_eff;
        col_c    = wrap ? '0 : col_pre;
        slot_c   = wrap ? 2'd0 : slot_pre;
        row_c    = roll ? '0 : r_row;
        row_plus = HW'(row_c) + HW'(1);
        last_row = row_plus >= h_eff;

        finish    = col_c != '0;
        has_left  = col_c >= CW'(2);
        has_right = col_c < w_eff;
        has_above = row_c != '0;
        has_below = !last_row;
        wr_en     = col_c < w_eff;

        slot_x  = dec3(slot_c);
        slot_xm = inc3(slot_c);

        addr_above = addr_of(slot_x, has_above ? row_c - RW'(1) : row_c);
        addr_below = addr_of(slot_x, has_below ? RW'(row_plus) : row_c);
        addr_cell  = addr_of(slot_x, row_c);
        addr_left  = addr_of(slot_xm, row_c);
        addr_wr    = addr_of(slot_c, row_c);

        // advance to the next raster position
        if (last_row) begin
            n_row  = '0;
            n_col  = (col_c >= w_eff) ? '0 : col_c + CW'(1);
            n_slot = (col_c >= w_eff) ? 2'd0 : inc3(slot_c);
        end else begin
            n_row  = RW'(row_plus);
            n_col  = col_c;
            n_slot = slot_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= 2'd0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    // mirrored column stores: copy A serves the vertical neighbors,
    // copy B the cell itself and its left neighbor
    logic r_store_a [DEPTH];
    logic r_store_b [DEPTH];
    logic r_rd_above, r_rd_below, r_rd_cell, r_rd_left;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (wr_en) begin
                r_store_a[addr_wr] <= i_cell_solid;
            end
            r_rd_above <= r_store_a[addr_above];
            r_rd_below <= r_store_a[addr_below];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (wr_en) begin
                r_store_b[addr_wr] <= i_cell_solid;
            end
            r_rd_cell <= r_store_b[addr_cell];
            r_rd_left <= r_store_b[addr_left];
        end
    end

    // classification stage
    logic          r_s1_valid;
    logic          r_s1_finish, r_s1_has_above, r_s1_has_below, r_s1_has_left, r_s1_has_right;
    logic          r_s1_solid;
    logic [CW-1:0] r_s1_x;
    logic [RW-1:0] r_s1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_go) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_finish    <= finish;
            r_s1_has_above <= has_above;
            r_s1_has_below <= has_below;
            r_s1_has_left  <= has_left;
            r_s1_has_right <= has_right;
            r_s1_solid     <= i_cell_solid;
            r_s1_x         <= col_c - CW'(1);
            r_s1_y         <= row_c;
        end
    end

    logic           e_top, e_right, e_bottom, e_left;
    logic [PXW-1:0] prod_x;
    logic [PYW-1:0] prod_y;

    always_comb begin
        e_top    = r_s1_has_above & !r_rd_above;
        e_bottom = r_s1_has_below & !r_rd_below;
        e_left   = r_s1_has_left & !r_rd_left;
        e_right  = r_s1_has_right & !r_s1_solid;
        emit     = r_s1_finish & r_rd_cell & (e_top | e_right | e_bottom | e_left);

        prod_x = PXW'(r_s1_x) * PXW'(i_cell_size);
        prod_y = PYW'(r_s1_y) * PYW'(i_cell_size);

        o_job.mask = build_mask(e_top, e_right, e_bottom, e_left);
        o_job.x0   = prod_x[COORD_W-1:0];
        o_job.x1   = prod_x[COORD_W-1:0] + COORD_W'(i_cell_size);
        o_job.y0   = prod_y[COORD_W-1:0];
        o_job.y1   = prod_y[COORD_W-1:0] + COORD_W'(i_cell_size);
    end

    // hold the stage only while it carries a job the queue cannot take
    assign s1_go      = !r_s1_valid || !emit || !i_q_stat.full;
    assign o_in_ready = s1_go;
    assign accept     = i_in_valid && s1_go;
    assign o_push     = r_s1_valid && emit && !i_q_stat.full;

endmodule

FILE: sv/bgbe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbe_queue: job queue between classification and result sequencing
// Small register queue; lets the intake keep running while a burst of
// results is drained.
// ----------------------------------------------------------------------------
module bgbe_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bgbe_pkg::t_job       i_job,
    input  logic                 i_pop,
    output bgbe_pkg::t_job       o_head,
    output bgbe_pkg::t_fifo_stat o_stat
);
    import bgbe_pkg::*;

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_entry[r_rd_ptr];
    assign o_stat.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;

endmodule

FILE: sv/bgbe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbe_back: result sequencer
// Walks the head job's firing positions in order into an output register,
// one result per cycle unless stalled; pops the job with its last result.
// ----------------------------------------------------------------------------
module bgbe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bgbe_pkg::t_job       i_job,
    input  bgbe_pkg::t_fifo_stat i_q_stat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bgbe_pkg::t_result    o_result,
    output logic                 o_last
);
    import bgbe_pkg::*;

    logic               r_valid;
    logic [N_SLOTS-1:0] r_done;
    t_result            r_result;
    logic               r_last;

    logic [N_SLOTS-1:0] rem, pick;
    logic [SLOT_W-1:0]  idx;
    logic               pick_last, load;

    always_comb begin
        rem       = i_job.mask & ~r_done;
        pick      = rem & (~rem + N_SLOTS'(1));
        pick_last = (rem & ~pick) == '0;
        idx       = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (pick[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
        load  = (!r_valid || i_ready) && !i_q_stat.empty;
        o_pop = load && pick_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= pick_last ? '0 : (r_done | pick);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= slot_result(idx, i_job);
            r_last   <= pick_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

endmodule

FILE: sv/binary_grid_boundary_edges.sv
`timescale 1ns / 1ps
// Path: a cell that finishes a solid boundary cell is registered with its
//   column store reads, written to the queue, then loaded into the output register.
// Throughput: one cell per cycle while the queue has room; the sequencer emits
//   one result per cycle while the output is not stalled.
// Reset: sizes return to 200 x 200 cells of 5 pixels, position to column 0,
//   row 0; the column store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// binary_grid_boundary_edges: boundary edge extraction for an occupancy grid
// Takes cells column by column, finishes the cell to the left of each one
// and emits boundary segments and their corner points as a stream.
// ----------------------------------------------------------------------------
module binary_grid_boundary_edges #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // cell stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [0] cell_solid
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [55:0]                     m_axis_tdata,  // start_x, start_y, end_x, end_y
    output logic [0:0]                      m_axis_tuser,  // item_kind
    output logic                            m_axis_tlast,  // run_last
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [bgbe_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bgbe_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import bgbe_pkg::*;

    // Configuration registers; a write to an unused index is dropped.
    logic [SIZE_W-1:0] r_grid_width, r_grid_height;
    logic [CELL_W-1:0] r_cell_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SIZE_W'(200);
            r_grid_height <= SIZE_W'(200);
            r_cell_size   <= CELL_W'(5);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata[SIZE_W-1:0];
                CFG_CELL_SIZE:   r_cell_size   <= i_cfg_wdata[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: position tracking, column store, classification into jobs.
    t_job       front_job, q_head;
    logic       q_push, q_pop;
    t_fifo_stat q_stat;

    bgbe_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_cell_solid  (s_axis_tdata[0]),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_cell_size   (r_cell_size),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_job         (front_job)
    );

    // Queue: decouples intake from result bursts.
    bgbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // Back: one result per cycle into the output register while not stalled.
    t_result out_res;
    logic    out_last;

    bgbe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res),
        .o_last   (out_last)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {4'b0000, out_res.ey, out_res.ex, out_res.sy, out_res.sx};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_last;

    // Never pop an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("job queue popped while empty");

    // Never push into a full queue.
    a_push_nonfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("job queue pushed while full");

    // A corner point starts and ends at the same place.
    a_point_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_res.kind == KIND_POINT) |->
            (out_res.sx == out_res.ex && out_res.sy == out_res.ey))
        else $error("corner point with distinct end");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
